### design/gps_pkg.sv
// Shared types and constants for the game pad poll serial master.
package gps_pkg;

  // Frame lengths in bytes.
  localparam int unsigned SHORT_FRAME_BYTES = 9;
  localparam int unsigned FULL_FRAME_BYTES  = 21;

  // Byte counter is wide enough to hold the full frame length itself.
  localparam int unsigned BYTE_CNT_W = $clog2(FULL_FRAME_BYTES + 1);

  // Register field widths.
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HALF_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP_TICKS   = 1'b1;

  // Configuration reset values.
  localparam logic [TICK_W-1:0] CLOCK_HALF_RESET = 16'd100;
  localparam logic [TICK_W-1:0] BYTE_GAP_RESET   = 16'd200;

  // Transmit bytes and the reply code that selects the long frame.
  localparam logic [7:0] TX_BYTE0      = 8'h01;
  localparam logic [7:0] TX_BYTE1      = 8'h42;
  localparam logic [7:0] FULL_REPLY_ID = 8'h79;

  // Timing configuration as seen by the sequencer.
  typedef struct packed {
    logic [TICK_W-1:0] clock_half_ticks;
    logic [TICK_W-1:0] byte_gap_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       busy_res;
    logic       frame_last;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       attention_line;
    logic       command_line;
    logic       clock_line;
  } result_t;

endpackage

### design/gamepad_poll_serial_master.sv
// Top level of the game pad poll serial master.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: poll_request, data_line (one tick per item)
//   m_axis    out        tdata: pad lines, received byte, busy; tlast: frame_last
//   cfg       in         write enable, index, 16-bit data (two timing registers)
//
// Each accepted item is one tick and yields one result item, registered in the cycle after.
// One item is accepted every cycle while the sink keeps up; the output
// register frees in the same cycle that its item is taken.
// Reset clears the sequencer to idle and loads the timing defaults.
// A stall on the output holds the input side off; no tick is lost.
module gamepad_poll_serial_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items; tdata bit 0 poll_request, bit 1 data_line, bits 7:2 zero.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // Result items; tdata bit 0 clock_line, 1 command_line, 2 attention_line,
  // 3 byte_valid, 11:4 byte_value, 16:12 byte_index, 17 busy_res, 23:18 zero.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [gps_pkg::TICK_W-1:0]    cfg_wdata_i
);

  gps_pkg::cfg_t    cfg;
  gps_pkg::result_t core_res;
  gps_pkg::result_t out_res;
  logic             space;
  logic             accept;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  gps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gps_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .poll_request_i (s_axis_tdata[0]),
    .data_line_i    (s_axis_tdata[1]),
    .cfg_i          (cfg),
    .result_o       (core_res)
  );

  gps_out_buf u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (core_res),
    .take_i   (m_axis_tready),
    .space_o  (space),
    .valid_o  (m_axis_tvalid),
    .result_o (out_res)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tdata = {6'd0,
                         out_res.busy_res,
                         out_res.byte_index,
                         out_res.byte_value,
                         out_res.byte_valid,
                         out_res.attention_line,
                         out_res.command_line,
                         out_res.clock_line};
  assign m_axis_tlast = out_res.frame_last;

endmodule

### design/gps_cfg_regs.sv
// Timing configuration registers written through the plain write port.
module gps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [gps_pkg::TICK_W-1:0]     cfg_wdata_i,
  output gps_pkg::cfg_t                  cfg_o
);

  gps_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        gps_pkg::CFG_CLOCK_HALF_TICKS: cfg_d.clock_half_ticks = cfg_wdata_i;
        gps_pkg::CFG_BYTE_GAP_TICKS:   cfg_d.byte_gap_ticks   = cfg_wdata_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_half_ticks <= gps_pkg::CLOCK_HALF_RESET;
      cfg_q.byte_gap_ticks   <= gps_pkg::BYTE_GAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/gps_core.sv
// Frame sequencer: advances one tick per accepted item and forms its result.
module gps_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              poll_request_i,
  input  logic              data_line_i,
  input  gps_pkg::cfg_t     cfg_i,
  output gps_pkg::result_t  result_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_GAP  = 3'd1,
    PH_PRE  = 3'd2,
    PH_LOW  = 3'd3,
    PH_HIGH = 3'd4
  } phase_e;

  localparam int unsigned BCW = gps_pkg::BYTE_CNT_W;
  localparam int unsigned TW  = gps_pkg::TICK_W;

  phase_e          phase_q, phase_d;
  logic [TW-1:0]   tick_q, tick_d;
  logic [2:0]      bit_q, bit_d;
  logic [BCW-1:0]  byte_q, byte_d;
  logic [7:0]      shift_q, shift_d;
  logic [BCW-1:0]  flen_q, flen_d;

  logic [TW:0]     tick_next;
  logic            half_done;
  logic            gap_done;
  logic [7:0]      tx_byte;
  logic            tx_bit;
  logic [7:0]      shift_base;
  gps_pkg::result_t res;

  // Elapsed-tick compares: a phase always lasts at least one tick.
  assign tick_next = {1'b0, tick_q} + {{TW{1'b0}}, 1'b1};
  assign half_done = tick_next >= {1'b0, cfg_i.clock_half_ticks};
  assign gap_done  = tick_next >= {1'b0, cfg_i.byte_gap_ticks};

  // Command byte for the current position, sent least significant bit first.
  always_comb begin
    priority if (byte_q == BCW'(0)) begin
      tx_byte = gps_pkg::TX_BYTE0;
    end else if (byte_q == BCW'(1)) begin
      tx_byte = gps_pkg::TX_BYTE1;
    end else begin
      tx_byte = 8'h00;
    end
  end
  assign tx_bit = tx_byte[bit_q];

  assign shift_base = (bit_q == 3'd0) ? 8'h00 : shift_q;

  // Next state and result for this tick.
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    flen_d  = flen_q;

    res                = '0;
    res.clock_line     = 1'b1;
    res.command_line   = 1'b1;
    res.attention_line = (phase_q == PH_IDLE);
    res.busy_res       = (phase_q != PH_IDLE);

    unique case (phase_q)
      PH_IDLE: begin
        if (poll_request_i) begin
          phase_d = PH_GAP;
          tick_d  = '0;
          bit_d   = '0;
          byte_d  = '0;
          shift_d = '0;
          flen_d  = BCW'(gps_pkg::SHORT_FRAME_BYTES);
        end
      end
      PH_GAP: begin
        if (gap_done) begin
          tick_d  = '0;
          phase_d = (byte_q >= flen_q) ? PH_IDLE : PH_PRE;
        end else begin
          tick_d = tick_next[TW-1:0];
        end
      end
      PH_PRE: begin
        if (half_done) begin
          tick_d  = '0;
          bit_d   = '0;
          phase_d = PH_LOW;
        end else begin
          tick_d = tick_next[TW-1:0];
        end
      end
      PH_LOW: begin
        res.clock_line   = 1'b0;
        res.command_line = tx_bit;
        if (half_done) begin
          shift_d = shift_base | (8'(data_line_i) << bit_q);
          if (bit_q == 3'd7) begin
            // The second reply byte decides the frame length.
            if (byte_q == BCW'(1)) begin
              flen_d = (shift_d == gps_pkg::FULL_REPLY_ID) ?
                       BCW'(gps_pkg::FULL_FRAME_BYTES) :
                       BCW'(gps_pkg::SHORT_FRAME_BYTES);
            end
            res.byte_valid = 1'b1;
            res.byte_value = shift_d;
            res.byte_index = 5'(byte_q);
            res.frame_last = ({1'b0, byte_q} + (BCW+1)'(1)) == {1'b0, flen_d};
          end
          tick_d  = '0;
          phase_d = PH_HIGH;
        end else begin
          tick_d = tick_next[TW-1:0];
        end
      end
      PH_HIGH: begin
        res.command_line = tx_bit;
        if (half_done) begin
          tick_d = '0;
          if (bit_q == 3'd7) begin
            bit_d   = '0;
            byte_d  = byte_q + BCW'(1);
            phase_d = PH_GAP;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = PH_LOW;
          end
        end else begin
          tick_d = tick_next[TW-1:0];
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
        bit_d   = '0;
      end
    endcase
  end

  // State advances only on ticks that are accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      flen_q  <= BCW'(gps_pkg::SHORT_FRAME_BYTES);
    end else if (accept_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      flen_q  <= flen_d;
    end
  end

  assign result_o = res;

endmodule

### design/gps_out_buf.sv
// Output register that holds one result item until the sink takes it.
module gps_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gps_pkg::result_t  result_i,
  input  logic              take_i,
  output logic              space_o,
  output logic              valid_o,
  output gps_pkg::result_t  result_o
);

  logic             valid_q, valid_d;
  gps_pkg::result_t data_q;

  // Free when empty or when the held item leaves this cycle.
  assign space_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

### test/tb.sv
// Self-checking testbench for the game pad poll serial master, driven tick by tick.
`timescale 1ns / 100ps

module tb;

  // Run control.
  localparam int RANDOM_TICKS   = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // How the poll request bit is filled on ticks where it does not matter.
  localparam int REQ_NONE   = 0;
  localparam int REQ_RANDOM = 1;

  // Reply byte patterns for a scripted frame.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZEROS  = 2;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_GAP,
    SEQ_LEAD,
    SEQ_CLK_LOW,
    SEQ_CLK_HIGH
  } seq_phase_e;

  // One input item: a single tick of the pad lines.
  typedef struct packed {
    logic req;
    logic din;
  } pad_tick_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // Bit 0 poll_request, bit 1 data_line, bits 7:2 zero.
  logic [7:0]                    s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // Bit 0 clock_line, 1 command_line, 2 attention_line, 3 byte_valid,
  // 11:4 byte_value, 16:12 byte_index, 17 busy_res, 23:18 zero.
  logic [23:0]                   m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_we_i = 1'b0;
  logic [gps_pkg::CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [gps_pkg::TICK_W-1:0]    cfg_wdata_i = '0;

  // Stimulus and expectation stores.
  pad_tick_t        pending_ticks_q[$];
  gps_pkg::result_t expected_lines_q[$];
  int               pushed_ticks = 0;
  int               mismatch_cnt = 0;
  bit               in_taken = 1'b0;
  bit               calm = 1'b0;
  int               hold_ask = 0;
  int               hold_done = 0;
  int               send_gap = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;

  // Timing settings as the stimulus generator knows them.
  logic [gps_pkg::TICK_W-1:0] cur_half = gps_pkg::CLOCK_HALF_RESET;
  logic [gps_pkg::TICK_W-1:0] cur_gap  = gps_pkg::BYTE_GAP_RESET;

  // Shadow of the sequencer used for prediction.
  logic [gps_pkg::TICK_W-1:0] half_cfg  = gps_pkg::CLOCK_HALF_RESET;
  logic [gps_pkg::TICK_W-1:0] gap_cfg   = gps_pkg::BYTE_GAP_RESET;
  seq_phase_e                 ph        = SEQ_IDLE;
  logic [gps_pkg::TICK_W-1:0] tick_cnt  = '0;
  logic [2:0]                 bit_cnt   = '0;
  logic [4:0]                 byte_cnt  = '0;
  logic [7:0]                 rx_shift  = '0;
  logic [4:0]                 frame_len = 5'(gps_pkg::SHORT_FRAME_BYTES);

  gamepad_poll_serial_master u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock.
  always #2 clk_i = ~clk_i;

  // A phase ends on the tick where its elapsed count reaches the length.
  function automatic bit span_over(logic [gps_pkg::TICK_W-1:0] elapsed,
                                   logic [gps_pkg::TICK_W-1:0] len);
    return ({16'd0, elapsed} + 32'd1) >= {16'd0, len};
  endfunction

  // Advances the shadow sequencer by one tick and returns the result item it predicts.
  task automatic predict_tick(input logic req, input logic din,
                              output gps_pkg::result_t res);
    logic [7:0] tx_byte;
    logic       tx;
    res = '0;
    res.clock_line     = 1'b1;
    res.command_line   = 1'b1;
    res.attention_line = 1'b1;
    if (ph != SEQ_IDLE) begin
      res.attention_line = 1'b0;
      res.busy_res       = 1'b1;
    end
    tx_byte = (byte_cnt == 5'd0) ? gps_pkg::TX_BYTE0 :
              (byte_cnt == 5'd1) ? gps_pkg::TX_BYTE1 : 8'h00;
    tx = tx_byte[bit_cnt];
    case (ph)
      SEQ_IDLE: begin
        if (req) begin
          ph        = SEQ_GAP;
          tick_cnt  = '0;
          bit_cnt   = '0;
          byte_cnt  = '0;
          rx_shift  = '0;
          frame_len = 5'(gps_pkg::SHORT_FRAME_BYTES);
        end
      end
      SEQ_GAP: begin
        if (span_over(tick_cnt, gap_cfg)) begin
          tick_cnt = '0;
          ph = (byte_cnt >= frame_len) ? SEQ_IDLE : SEQ_LEAD;
        end else begin
          tick_cnt++;
        end
      end
      SEQ_LEAD: begin
        if (span_over(tick_cnt, half_cfg)) begin
          tick_cnt = '0;
          bit_cnt  = '0;
          ph       = SEQ_CLK_LOW;
        end else begin
          tick_cnt++;
        end
      end
      SEQ_CLK_LOW: begin
        res.clock_line   = 1'b0;
        res.command_line = tx;
        if (span_over(tick_cnt, half_cfg)) begin
          // The data line is sampled on the last tick of the low half.
          rx_shift = ((bit_cnt == 3'd0) ? 8'h00 : rx_shift) | (8'(din) << bit_cnt);
          if (bit_cnt == 3'd7) begin
            if (byte_cnt == 5'd1) begin
              frame_len = (rx_shift == gps_pkg::FULL_REPLY_ID) ?
                          5'(gps_pkg::FULL_FRAME_BYTES) :
                          5'(gps_pkg::SHORT_FRAME_BYTES);
            end
            res.byte_valid = 1'b1;
            res.byte_value = rx_shift;
            res.byte_index = byte_cnt;
            res.frame_last = (byte_cnt + 5'd1 == frame_len);
          end
          tick_cnt = '0;
          ph       = SEQ_CLK_HIGH;
        end else begin
          tick_cnt++;
        end
      end
      SEQ_CLK_HIGH: begin
        res.command_line = tx;
        if (span_over(tick_cnt, half_cfg)) begin
          tick_cnt = '0;
          if (bit_cnt == 3'd7) begin
            bit_cnt = '0;
            byte_cnt++;
            ph = SEQ_GAP;
          end else begin
            bit_cnt++;
            ph = SEQ_CLK_LOW;
          end
        end else begin
          tick_cnt++;
        end
      end
      default: begin
        ph       = SEQ_IDLE;
        tick_cnt = '0;
        bit_cnt  = '0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Monitor: tracks register writes, checks results and predicts accepted ticks.
  always @(posedge clk_i) begin
    gps_pkg::result_t want;
    gps_pkg::result_t got;
    gps_pkg::result_t res;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == gps_pkg::CFG_CLOCK_HALF_TICKS) begin
          half_cfg = cfg_wdata_i;
        end else begin
          gap_cfg = cfg_wdata_i;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.clock_line     = m_axis_tdata[0];
        got.command_line   = m_axis_tdata[1];
        got.attention_line = m_axis_tdata[2];
        got.byte_valid     = m_axis_tdata[3];
        got.byte_value     = m_axis_tdata[11:4];
        got.byte_index     = m_axis_tdata[16:12];
        got.busy_res       = m_axis_tdata[17];
        got.frame_last     = m_axis_tlast;
        if (expected_lines_q.size() == 0) begin
          $display("%0t: result item with none expected, expected none, actual %h/%b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatch_cnt++;
        end else begin
          want = expected_lines_q.pop_front();
          check_field("clock_line", want.clock_line, got.clock_line);
          check_field("command_line", want.command_line, got.command_line);
          check_field("attention_line", want.attention_line, got.attention_line);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("byte_value", want.byte_value, got.byte_value);
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("frame_last", want.frame_last, got.frame_last);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(s_axis_tdata[0], s_axis_tdata[1], res);
        expected_lines_q.push_back(res);
      end
    end
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: offers pending ticks with random idle bursts.
  always @(negedge clk_i) begin
    logic      nv;
    logic [7:0] nd;
    pad_tick_t it;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        nv = 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 9);
        nv = 1'b0;
      end else if (pending_ticks_q.size() > 0) begin
        it = pending_ticks_q.pop_front();
        nv = 1'b1;
        nd = {6'b0, it.din, it.req};
      end else begin
        nv = 1'b0;
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (hold_done != hold_ask) begin
      hold_done  = hold_ask;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  function automatic int half_eff();
    return (cur_half == 0) ? 1 : int'(cur_half);
  endfunction

  function automatic int gap_eff();
    return (cur_gap == 0) ? 1 : int'(cur_gap);
  endfunction

  // Ticks that any frame started now needs to finish, with a little margin.
  function automatic int full_frame_ticks();
    return 1 + gap_eff() + gps_pkg::FULL_FRAME_BYTES * (17 * half_eff() + gap_eff()) + 2;
  endfunction

  task automatic push_tick(input logic req, input logic din);
    pad_tick_t it;
    it.req = req;
    it.din = din;
    pending_ticks_q.push_back(it);
    pushed_ticks++;
  endtask

  task automatic queue_ticks(input int n, input int req_mode);
    for (int i = 0; i < n; i++) begin
      push_tick((req_mode == REQ_RANDOM) ? 1'($urandom_range(0, 1)) : 1'b0,
                1'($urandom_range(0, 1)));
    end
  endtask

  // Queues one frame from idle, with the reply bits on the sampling ticks.
  task automatic queue_frame(input int fill, input bit long_frame);
    logic [7:0] reply;
    int         hh;
    int         gg;
    int         n_bytes;
    hh = half_eff();
    gg = gap_eff();
    n_bytes = long_frame ? gps_pkg::FULL_FRAME_BYTES : gps_pkg::SHORT_FRAME_BYTES;
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    queue_ticks(gg, REQ_RANDOM);
    for (int b = 0; b < n_bytes; b++) begin
      case (fill)
        FILL_ONES:  reply = 8'hFF;
        FILL_ZEROS: reply = 8'h00;
        default:    reply = 8'($urandom_range(0, 255));
      endcase
      // The second reply byte decides the frame length.
      if (b == 1) begin
        if (long_frame) begin
          reply = gps_pkg::FULL_REPLY_ID;
        end else if (reply == gps_pkg::FULL_REPLY_ID) begin
          reply = ~reply;
        end
      end
      queue_ticks(hh, REQ_RANDOM);
      for (int k = 0; k < 8; k++) begin
        queue_ticks(hh - 1, REQ_RANDOM);
        push_tick(1'($urandom_range(0, 1)), reply[k]);
        queue_ticks(hh, REQ_RANDOM);
      end
      queue_ticks(gg, REQ_RANDOM);
    end
  endtask

  // Waits until every queued tick is taken and every result has arrived.
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (pending_ticks_q.size() != 0 || s_axis_tvalid || expected_lines_q.size() != 0);
  endtask

  task automatic write_reg(input logic [gps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gps_pkg::TICK_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gps_pkg::CFG_CLOCK_HALF_TICKS) begin
      cur_half = value;
    end else begin
      cur_gap = value;
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    int start_ticks;
    int pick;
    bit held;
    held = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle ticks, then a frame at the reset timing into the lead-in half.
    queue_ticks(6, REQ_NONE);
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    queue_ticks(240, REQ_RANDOM);
    settle();

    // Largest half period mid-frame, then cut short by a small one.
    write_reg(gps_pkg::CFG_CLOCK_HALF_TICKS, 16'hFFFF);
    queue_ticks(20, REQ_RANDOM);
    settle();
    write_reg(gps_pkg::CFG_CLOCK_HALF_TICKS, 16'd1);
    write_reg(gps_pkg::CFG_BYTE_GAP_TICKS, 16'd0);
    queue_ticks(full_frame_ticks(), REQ_NONE);
    settle();

    // Largest gap mid-frame, then a shorter one ends the gap at once.
    write_reg(gps_pkg::CFG_BYTE_GAP_TICKS, 16'hFFFF);
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    queue_ticks(20, REQ_RANDOM);
    settle();
    write_reg(gps_pkg::CFG_BYTE_GAP_TICKS, 16'd3);
    queue_ticks(full_frame_ticks(), REQ_NONE);
    settle();

    // Random part: mostly well-formed frames under changing timing.
    start_ticks = pushed_ticks;
    while (pushed_ticks - start_ticks < RANDOM_TICKS) begin
      settle();
      write_reg(gps_pkg::CFG_CLOCK_HALF_TICKS,
                ($urandom_range(0, 7) == 0) ? 16'($urandom_range(3, 4))
                                            : 16'($urandom_range(1, 2)));
      write_reg(gps_pkg::CFG_BYTE_GAP_TICKS, 16'($urandom_range(0, 3)));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_ticks(30, REQ_RANDOM);
        queue_ticks(full_frame_ticks(), REQ_NONE);
      end else if (pick == 1) begin
        queue_frame(($urandom_range(0, 1) == 0) ? FILL_ONES : FILL_ZEROS, 1'b0);
      end else begin
        queue_frame(FILL_RANDOM, $urandom_range(0, 2) == 0);
      end
      queue_ticks($urandom_range(0, 3), REQ_NONE);
      // One long hold-off on the result side while ticks keep coming.
      if (!held) begin
        held = 1'b1;
        hold_ask++;
      end
    end
    settle();

    // Final stretch without idling on either side: a long frame on a floating data line.
    calm = 1'b1;
    write_reg(gps_pkg::CFG_CLOCK_HALF_TICKS, 16'd1);
    write_reg(gps_pkg::CFG_BYTE_GAP_TICKS, 16'd1);
    queue_frame(FILL_ONES, 1'b1);
    settle();
    repeat (4) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_lines_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
